// ----- src/assert_macros.svh -----
// Assertion macros for the queue manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression that must hold at every clock edge outside reset.
`define SBMQ_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define SBMQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SBMQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sbmq_pkg.sv -----
// Types, constants and helpers shared by the shared-buffer queue manager.
`timescale 1ns / 1ps

package sbmq_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_QUEUES  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam int IDX_W   = $clog2(NUM_ENTRIES);
    localparam int PTR_W   = $clog2(NUM_ENTRIES + 1);
    localparam int QID_W   = 2;
    localparam int FIELD_W = 32;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_ENTRIES);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [FIELD_W-1:0] UNDERFLOW_DATA = '1;

    typedef struct packed {
        logic                      operation;
        logic [QID_W-1:0]          queue_id;
        logic signed [FIELD_W-1:0] data_in;
    } sbmq_cmd_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] data_out;
        logic [1:0]                status;
    } sbmq_res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [PTR_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } sbmq_link_req_t;

    function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
        return p < NULL_PTR;
    endfunction

endpackage

// ----- src/shared_buffer_multi_queue.sv -----
// Top level: several FIFO queues sharing one data store through a linked free list.
// An operation is accepted only in the idle state and then runs through the look,
// update and done steps, with a link step for an enqueue onto a non-empty queue;
// overflow and underflow skip to done. The next operation waits until done has handed
// on the result. The link RAM (one read, one write port) is read once per operation.
// Reset (asynchronous, active low) empties every queue and chains all entries into
// the free list at once; no clearing pass is needed.
`timescale 1ns / 1ps

module shared_buffer_multi_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sbmq_pkg::sbmq_cmd_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output sbmq_pkg::sbmq_res_t res
);
    import sbmq_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_UPDATE, S_LINK, S_DONE} state_t;

    state_t           state_reg;
    sbmq_cmd_t        cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] tail_old_reg;
    logic [FIELD_W-1:0] data_out_reg;
    logic [1:0]       status_reg;
    logic             res_valid_reg;
    sbmq_res_t        res_reg;
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] head_ptr_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_ptr_reg [NUM_QUEUES];

    logic [DATA_WIDTH-1:0] data_mem [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] data_rd_reg;

    sbmq_link_req_t   link_req;
    logic [PTR_W-1:0] link_rd;

    logic [QID_W-1:0] q;
    logic             q_ok;
    logic             is_enq;
    logic [PTR_W-1:0] head_q;
    logic [PTR_W-1:0] tail_q;
    logic [PTR_W-1:0] look_ptr;
    logic             look_ok;
    logic [PTR_W-1:0] idx_ptr;
    logic             res_free;
    logic             upd_enq;
    logic             upd_deq;
    logic             link_quiet;
    logic             in_done;

    assign q        = cmd_reg.queue_id;
    assign q_ok     = int'(q) < NUM_QUEUES;
    assign is_enq   = cmd_reg.operation == OP_ENQ;
    assign head_q   = head_ptr_reg[q];
    assign tail_q   = tail_ptr_reg[q];
    // An enqueue takes the head of the free list, a dequeue the head of its queue.
    assign look_ptr = is_enq ? free_head_reg : head_q;
    assign look_ok  = q_ok && ptr_valid(look_ptr);
    assign idx_ptr  = PTR_W'(idx_reg);
    assign res_free = !res_valid_reg || !res_stall;

    assign upd_enq    = state_reg == S_UPDATE && is_enq;
    assign upd_deq    = state_reg == S_UPDATE && !is_enq;
    assign link_quiet = state_reg == S_IDLE || state_reg == S_LOOK || state_reg == S_DONE;
    assign in_done    = state_reg == S_DONE;

    assign cmd_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        link_req       = '0;
        link_req.raddr = look_ptr[IDX_W-1:0];
        unique case (state_reg)
            S_UPDATE:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = idx_reg;
                link_req.wdata = is_enq ? NULL_PTR : free_head_reg;
            end
            S_LINK:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = tail_old_reg;
                link_req.wdata = idx_ptr;
            end
            default:
            begin
            end
        endcase
    end

    sbmq_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rd)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE && is_enq)
        begin
            data_mem[idx_reg] <= cmd_reg.data_in[DATA_WIDTH-1:0];
        end
        data_rd_reg <= data_mem[look_ptr[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            tail_old_reg  <= '0;
            data_out_reg  <= '0;
            status_reg    <= ST_OK;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            free_head_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_ptr_reg[i] <= NULL_PTR;
                tail_ptr_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            // In the done step the result register is handled below.
            if (res_valid_reg && !res_stall && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (!look_ok)
                    begin
                        status_reg   <= is_enq ? ST_OVERFLOW : ST_UNDERFLOW;
                        data_out_reg <= is_enq ? '0 : UNDERFLOW_DATA;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= look_ptr[IDX_W-1:0];
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    status_reg <= ST_OK;
                    if (is_enq)
                    begin
                        data_out_reg    <= '0;
                        free_head_reg   <= link_rd;
                        tail_ptr_reg[q] <= idx_ptr;
                        if (!ptr_valid(head_q))
                        begin
                            head_ptr_reg[q] <= idx_ptr;
                            state_reg       <= S_DONE;
                        end
                        else if (ptr_valid(tail_q))
                        begin
                            // The old tail must point at the new entry: a second write.
                            tail_old_reg <= tail_q[IDX_W-1:0];
                            state_reg    <= S_LINK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        data_out_reg    <= FIELD_W'(data_rd_reg);
                        head_ptr_reg[q] <= link_rd;
                        free_head_reg   <= idx_ptr;
                        state_reg       <= S_DONE;
                    end
                end
                S_LINK:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_free)
                    begin
                        res_reg.data_out <= data_out_reg;
                        res_reg.status   <= status_reg;
                        res_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SBMQ_ASSERT_NXT(a_enq_sets_tail, upd_enq, tail_q == idx_ptr, "tail not moved by enqueue")
    `SBMQ_ASSERT_NXT(a_deq_frees_entry, upd_deq, free_head_reg == idx_ptr, "entry not freed")
    `SBMQ_ASSERT_IMP(a_link_write_window, link_quiet, !link_req.we, "stray link write")
    `SBMQ_ASSERT_IMP(a_result_from_done, $rose(res_valid_reg), $past(in_done), "stray result")

endmodule

// ----- src/sbmq_link_ram.sv -----
// Link store: RAM of next pointers (one read, one write port) with per-entry valid bits.
`timescale 1ns / 1ps

module sbmq_link_ram (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbmq_pkg::sbmq_link_req_t req,
    output logic [sbmq_pkg::PTR_W-1:0] rd_data
);
    import sbmq_pkg::*;

    logic [PTR_W-1:0]       mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic                   rvalid_reg;
    logic [PTR_W-1:0]       rdata_reg;
    logic [IDX_W-1:0]       raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[req.raddr];
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
        raddr_reg <= req.raddr;
    end

    // An entry never written since reset still holds its initial chain link.
    assign rd_data = rvalid_reg ? rdata_reg : (PTR_W'(raddr_reg) + PTR_W'(1));

endmodule
